@@ hdl/gcode_line_filter_assert.svh @@
// assertion macros used by the checker module
`ifndef GCODE_LINE_FILTER_ASSERT_SVH
`define GCODE_LINE_FILTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define GCF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gcf assertion failed");

// next-cycle implication, held off during reset
`define GCF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gcf assertion failed");

`endif

@@ hdl/gcf_pkg.sv @@
// package: types, codes and constants of the line filter
`timescale 1ns / 1ps

package gcf_pkg;

    localparam int GCF_LINE_DEPTH = 64;

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_ERR  = 2'd2;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } gcf_in_t;

    typedef struct packed {
        logic [7:0] line_char;
        logic       last_char;
    } gcf_out_t;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic advance;
    } gcf_cmd_t;

    typedef struct packed {
        logic emit;
        logic last;
    } gcf_sts_t;

endpackage

@@ hdl/gcode_line_filter.sv @@
// top level: g-code line filter
// a byte request that emits nothing is taken in the idle state and ready stays high
// a byte request ending a line of n kept characters occupies the block until all n are read out
// each char is a line store read in the fetch state, then held in the show state until m_ready
// input is refused while a line is read out; output starts after the fetch state's store read
// synchronous active-low reset clears fill count, skip flag and controller; store is not cleared
`timescale 1ns / 1ps

module gcode_line_filter #(
    parameter int LINE_DEPTH = gcf_pkg::GCF_LINE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gcf_pkg::gcf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gcf_pkg::gcf_out_t m_data
);

    gcf_pkg::gcf_cmd_t cmd;
    gcf_pkg::gcf_sts_t sts;

    gcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gcf_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

endmodule

@@ hdl/gcf_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module gcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/gcf_ctrl.sv @@
// controller: request intake and per-character readout sequencing
`timescale 1ns / 1ps

module gcf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  gcf_pkg::gcf_sts_t sts,
    output gcf_pkg::gcf_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next  = state_reg;
        cmd.take    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.take = 1'b1;
                    if (sts.emit) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    state_next  = sts.last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = (state_next == ST_SHOW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

@@ hdl/gcf_dp.sv @@
// datapath: line store, fill and trim counters, skip flag, readout pointer
`timescale 1ns / 1ps

module gcf_dp #(
    parameter int LINE_DEPTH = gcf_pkg::GCF_LINE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  gcf_pkg::gcf_in_t  in_data,
    input  gcf_pkg::gcf_cmd_t cmd,
    output gcf_pkg::gcf_sts_t sts,
    output gcf_pkg::gcf_out_t out_data
);

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_DEPTH - 1);

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          skip_reg, skip_next;

    logic [CW-1:0] fill_inc;
    logic [CW-1:0] emit_len;
    logic [CW-1:0] keep_dec;
    logic          emit;
    logic          emit_go;
    logic          store;
    logic          is_data;
    logic          is_end;
    logic [7:0]    ch;
    logic [7:0]    rd_data;

    always_comb begin
        ch        = in_data.data_byte;
        is_data   = (in_data.command == gcf_pkg::CMD_DATA);
        is_end    = (in_data.command == gcf_pkg::CMD_END);
        fill_inc  = fill_reg + CW'(1);
        emit      = 1'b0;
        store     = 1'b0;
        emit_len  = keep_reg;
        keep_dec  = keep_reg;
        skip_next = skip_reg;
        if (is_end) begin
            emit = (fill_reg != '0) && !skip_reg;
        end else if (is_data) begin
            if (ch == gcf_pkg::CH_LF) begin
                if (skip_reg) begin
                    skip_next = 1'b0;
                end else begin
                    emit = (fill_reg != '0);
                end
            end else if (skip_reg || (ch == gcf_pkg::CH_CR)) begin
                emit = 1'b0;
            end else if ((ch == gcf_pkg::CH_SP) && (fill_reg == '0)) begin
                emit = 1'b0;
            end else if (ch == gcf_pkg::CH_SEMI) begin
                skip_next = 1'b1;
                emit      = (fill_reg != '0);
            end else begin
                store = 1'b1;
                if (ch != gcf_pkg::CH_SP) begin
                    keep_dec = fill_inc;
                end
                emit_len = keep_dec;
                if (fill_inc >= FULL_COUNT) begin
                    skip_next = 1'b1;
                    emit      = 1'b1;
                end
            end
        end
        emit_go = emit && (emit_len != '0);
    end

    always_comb begin
        fill_next = fill_reg;
        keep_next = keep_reg;
        len_next  = len_reg;
        ptr_next  = ptr_reg;
        if (cmd.take) begin
            if (store) begin
                fill_next = fill_inc;
                keep_next = keep_dec;
            end
            if (emit) begin
                fill_next = '0;
                keep_next = '0;
            end
            if (emit_go) begin
                len_next = emit_len;
                ptr_next = '0;
            end
        end else if (cmd.advance) begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            keep_reg <= '0;
            skip_reg <= 1'b0;
            len_reg  <= '0;
            ptr_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            keep_reg <= keep_next;
            len_reg  <= len_next;
            ptr_reg  <= ptr_next;
            if (cmd.take) begin
                skip_reg <= skip_next;
            end
        end
    end

    gcf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.take && store),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (ch),
        .rd_en   (cmd.rd_en),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign sts.emit           = emit_go;
    assign sts.last           = ((ptr_reg + CW'(1)) == len_reg);
    assign out_data.line_char = rd_data;
    assign out_data.last_char = sts.last;

endmodule

@@ hdl/gcf_checker.sv @@
// port-level checker for the line filter and its bind
`timescale 1ns / 1ps
`include "gcode_line_filter_assert.svh"

module gcf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input gcf_pkg::gcf_out_t m_data
);

    `GCF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `GCF_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `GCF_ASSERT_NEXT(a_last_gap, aclk, aresetn, m_valid && m_ready && m_data.last_char, !m_valid)
    `GCF_ASSERT_NEXT(a_line_busy, aclk, aresetn, m_valid && m_ready && !m_data.last_char, !s_ready)

endmodule

bind gcode_line_filter gcf_checker u_gcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/tb_gcode_line_filter.sv @@
// testbench of the g-code line filter: directed table then random text, checked by a line predictor
`timescale 1ns / 1ps

module tb_gcode_line_filter;

    localparam int BUF = gcf_pkg::GCF_LINE_DEPTH;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 27;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] val;
        logic       typed;
        logic [1:0] n_out;
        logic [7:0] out_char;
    } dir_row_t;

    // typed rows give the output they must produce, the others use the predictor
    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_LF,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_CR,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SP,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SEMI, 1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'h78,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_LF,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'h47,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_LF,   1'b1, 2'd1, 8'h47},
        '{gcf_pkg::CMD_DATA, 8'h00,            1'b0, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'hFF,            1'b0, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SP,   1'b0, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SP,   1'b0, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SEMI, 1'b0, 2'd0, 8'h00},
        '{gcf_pkg::CMD_ERR,  8'hFF,            1'b1, 2'd0, 8'h00},
        '{CMD_SPARE,         8'h55,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_LF,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'h4D,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_CR,   1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_END,  8'hAA,            1'b1, 2'd1, 8'h4D},
        '{gcf_pkg::CMD_END,  8'h00,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'h62,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_SEMI, 1'b1, 2'd1, 8'h62},
        '{gcf_pkg::CMD_END,  8'hFF,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, 8'h63,            1'b1, 2'd0, 8'h00},
        '{gcf_pkg::CMD_DATA, gcf_pkg::CH_LF,   1'b1, 2'd0, 8'h00}
    };

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    gcf_pkg::gcf_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    gcf_pkg::gcf_out_t m_data;

    // predictor state
    logic [7:0]  held_chars [0:BUF-1];
    int unsigned held_fill = 0;
    bit          skipping = 1'b0;

    gcf_pkg::gcf_out_t fresh_chars [$];
    gcf_pkg::gcf_out_t pending_chars [$];
    int                err_cnt = 0;
    int                item_cnt = 0;
    int                cycle_cnt = 0;
    bit                quiet = 1'b0;

    gcode_line_filter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[gcode_line_filter] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (quiet || !aresetn) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // trailing spaces trimmed, then the held line goes out
    task automatic flush_held();
        int unsigned n;
        int unsigned k;
        gcf_pkg::gcf_out_t r;
        n = held_fill;
        while (n > 0 && held_chars[n-1] == gcf_pkg::CH_SP) n--;
        for (k = 0; k < n; k++) begin
            r.line_char = held_chars[k];
            r.last_char = (k + 1 == n);
            fresh_chars.push_back(r);
        end
        held_fill = 0;
    endtask

    task automatic filter_predict(input logic [1:0] cmd, input logic [7:0] ch);
        fresh_chars.delete();
        if (cmd == gcf_pkg::CMD_END) begin
            if (held_fill != 0 && !skipping) flush_held();
        end else if (cmd == gcf_pkg::CMD_DATA) begin
            if (ch == gcf_pkg::CH_LF) begin
                if (skipping) skipping = 1'b0;
                else if (held_fill != 0) flush_held();
            end else if (skipping || ch == gcf_pkg::CH_CR ||
                         (ch == gcf_pkg::CH_SP && held_fill == 0)) begin
            end else if (ch == gcf_pkg::CH_SEMI) begin
                skipping = 1'b1;
                if (held_fill != 0) flush_held();
            end else begin
                if (held_fill < BUF) begin
                    held_chars[held_fill] = ch;
                    held_fill++;
                end
                if (held_fill >= BUF - 1) begin
                    skipping = 1'b1;
                    flush_held();
                end
            end
        end
    endtask

    task automatic send_req(input logic [1:0] cmd, input logic [7:0] val,
                            input bit typed = 1'b0, input int n_out = 0,
                            input logic [7:0] out_char = 8'h00);
        gcf_pkg::gcf_out_t r;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {cmd, val};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_predict(cmd, val);
        if (typed) begin
            if (n_out == 1) begin
                r.line_char = out_char;
                r.last_char = 1'b1;
                pending_chars.push_back(r);
            end
        end else begin
            foreach (fresh_chars[i]) pending_chars.push_back(fresh_chars[i]);
        end
        item_cnt++;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 7) return 8'($urandom_range(8'h2D, 8'h39));
        if (r == 7) return gcf_pkg::CH_SP;
        if (r == 8) return gcf_pkg::CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_text_line();
        int lead;
        int len;
        int kind;
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 15) == 0) len = $urandom_range(BUF - 6, BUF + 10);
        else len = $urandom_range(0, 12);
        kind = $urandom_range(0, 9);
        repeat (lead) send_req(gcf_pkg::CMD_DATA, gcf_pkg::CH_SP);
        repeat (len) send_req(gcf_pkg::CMD_DATA, pick_char());
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_req(gcf_pkg::CMD_DATA, gcf_pkg::CH_SP);
        end
        if (kind < 2) begin
            send_req(gcf_pkg::CMD_DATA, gcf_pkg::CH_SEMI);
            repeat ($urandom_range(0, 5)) send_req(gcf_pkg::CMD_DATA, pick_char());
        end
        if (kind == 2) send_req(gcf_pkg::CMD_DATA, gcf_pkg::CH_CR);
        if (kind == 3) send_req(gcf_pkg::CMD_END, 8'($urandom_range(0, 255)));
        else send_req(gcf_pkg::CMD_DATA, gcf_pkg::CH_LF);
    endtask

    always @(posedge aclk) begin
        gcf_pkg::gcf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected result: line_char %02h last_char %0b",
                       m_data.line_char, m_data.last_char);
                err_cnt++;
            end else begin
                want = pending_chars.pop_front();
                if (m_data.line_char !== want.line_char) begin
                    $error("line_char: expected %02h, actual %02h",
                           want.line_char, m_data.line_char);
                    err_cnt++;
                end
                if (m_data.last_char !== want.last_char) begin
                    $error("last_char: expected %0b, actual %0b",
                           want.last_char, m_data.last_char);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_req(DIR_TAB[i].cmd, DIR_TAB[i].val, DIR_TAB[i].typed,
                     DIR_TAB[i].n_out, DIR_TAB[i].out_char);
        end

        while (item_cnt < DIR_ROWS + RANDOM_ITEMS) begin
            quiet = (item_cnt >= DIR_ROWS + 150 && item_cnt < DIR_ROWS + 240);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end else begin
                send_text_line();
            end
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (4 * BUF + 16) @(posedge aclk);

        if (err_cnt == 0 && pending_chars.size() == 0) begin
            $display("[gcode_line_filter] OK");
        end else begin
            $display("[gcode_line_filter] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/gcf_pkg.sv
hdl/gcf_ram.sv
hdl/gcf_ctrl.sv
hdl/gcf_dp.sv
hdl/gcode_line_filter.sv
hdl/gcf_checker.sv
test/tb_gcode_line_filter.sv
